// File: design/u2g_pkg.sv
// Shared types, constants and code-page tables for the UTF-8 to GBK converter.
package u2g_pkg;

    localparam int TABLE_ENTRIES = 49;
    localparam int ROM_SIZE      = 49;
    localparam int SEARCH_LIMIT  = (TABLE_ENTRIES < ROM_SIZE) ? TABLE_ENTRIES : ROM_SIZE;
    localparam int IDX_W         = $clog2(ROM_SIZE);
    localparam int CNT_W         = IDX_W + 1;

    localparam logic [15:0] MAX_OUT_RESET = 16'hFFFF;

    localparam logic [1:0] PH_IDLE         = 2'd0;
    localparam logic [1:0] PH_TWO_LAST     = 2'd1;
    localparam logic [1:0] PH_THREE_SECOND = 2'd2;
    localparam logic [1:0] PH_THREE_LAST   = 2'd3;

    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_CODE  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_CODE  = 8'hE0;
    localparam logic [15:0] ASCII_LIMIT = 16'h0080;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_SEARCH  = 6'b000010,
        ST_EMIT_HI = 6'b000100,
        ST_EMIT_LO = 6'b001000,
        ST_EMIT_1  = 6'b010000,
        ST_STATUS  = 6'b100000
    } state_t;

    localparam logic [15:0] ROM_CP [ROM_SIZE] = '{
        16'h3002, 16'h4E00, 16'h4E4B, 16'h4F60, 16'h4F7F, 16'h5206, 16'h524D,
        16'h52A8, 16'h5408, 16'h542F, 16'h5462, 16'h571F, 16'h5757, 16'h5883,
        16'h5BB6, 16'h5DF2, 16'h5E26, 16'h5EA6, 16'h5F53, 16'h5F97, 16'h6210,
        16'h6211, 16'h6444, 16'h690D, 16'h6A21, 16'h6B22, 16'h6BCF, 16'h6C0F,
        16'h6C34, 16'h6E29, 16'h6E7F, 16'h6EF4, 16'h7269, 16'h73AF, 16'h7528,
        16'h767E, 16'h7684, 16'h76C6, 16'h7740, 16'h78B1, 16'h7BA1, 16'h8BB0,
        16'h8BED, 16'h8C22, 16'h8FCE, 16'h90FD, 16'h9178, 16'h97F3, 16'hFF0C
    };

    localparam logic [15:0] ROM_GBK [ROM_SIZE] = '{
        16'hA1A3, 16'hD2BB, 16'hD6AE, 16'hC4E3, 16'hCAB9, 16'hB7D6, 16'hC7B0,
        16'hB6AF, 16'hBACF, 16'hC6F4, 16'hC4D8, 16'hCDBF, 16'hBFE9, 16'hBEF9,
        16'hBCD2, 16'hD2D1, 16'hB4F8, 16'hB6C8, 16'hB5B1, 16'hB5C3, 16'hB3C9,
        16'hCED2, 16'hC9E3, 16'hD6B2, 16'hC4A3, 16'hBBB6, 16'hC3BF, 16'hCAC7,
        16'hCBAE, 16'hCEC2, 16'hCAAA, 16'hB5CE, 16'hCEEF, 16'hBBB7, 16'hD3C3,
        16'hB0D9, 16'hB5C4, 16'hC5E8, 16'hD5C5, 16'hBCE1, 16'hB9DC, 16'hBCC7,
        16'hD3EF, 16'hD0BB, 16'hD3AD, 16'hB6BC, 16'hCBD8, 16'hD2F4, 16'hA3AC
    };

endpackage

// File: design/utf8_to_gbk_stream_converter.sv
// Top level of the UTF-8 to GBK stream converter with its binary-search sequencer.
// Sequence: an ASCII byte is accepted in ST_IDLE and sent from ST_EMIT_1; a multibyte
// character runs a binary search over SEARCH_LIMIT entries in ST_SEARCH, then ST_EMIT_HI and ST_EMIT_LO.
// A new input byte is taken only in ST_IDLE, so the converter does not accept the next byte
// before it is through with the last one; an end-of-string item adds its status item from ST_STATUS.
// Reset (synchronous, active low) clears the decode state and the count, and sets
// max_out to 65535.
module utf8_to_gbk_stream_converter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte [7:0]
    input  logic        s_tlast,   // end_of_string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_byte [7:0], total_length [23:8]
    output logic        m_tlast,   // run_last
    output logic [1:0]  m_tuser    // is_status [0], overflowed [1]
);

    localparam int CW = u2g_pkg::CNT_W;
    localparam int IW = u2g_pkg::IDX_W;

    u2g_pkg::state_t state_reg, state_next;
    logic [1:0]  phase_reg, phase_next;
    logic [15:0] partial_reg, partial_next;
    logic [15:0] bytes_reg, bytes_next;
    logic        ovf_reg, ovf_next;
    logic [15:0] max_reg;
    logic [15:0] cp_reg, cp_next;
    logic        end_reg, end_next;
    logic [CW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [15:0] pair_reg, pair_next;
    logic [7:0]  single_reg, single_next;
    logic        mv_reg, mv_next;
    logic [7:0]  mbyte_reg, mbyte_next;
    logic [15:0] mlen_reg, mlen_next;
    logic        mlast_reg, mlast_next;
    logic        mstat_reg, mstat_next;
    logic        movf_reg, movf_next;

    logic [15:0] dec_cp;
    logic [CW:0] mid_sum;
    logic [CW-1:0] mid;
    logic [15:0] rom_key, rom_val;
    logic        out_free, accept;

    assign s_tready = (state_reg == u2g_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !mv_reg || m_tready;
    assign dec_cp   = partial_reg | {10'b0, s_tdata[5:0]};
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_sum[CW:1];
    assign rom_key  = u2g_pkg::ROM_CP[mid[IW-1:0]];
    assign rom_val  = u2g_pkg::ROM_GBK[mid[IW-1:0]];

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        partial_next = partial_reg;
        bytes_next   = bytes_reg;
        ovf_next     = ovf_reg;
        cp_next      = cp_reg;
        end_next     = end_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        pair_next    = pair_reg;
        single_next  = single_reg;
        mv_next      = mv_reg && !m_tready;
        mbyte_next   = mbyte_reg;
        mlen_next    = mlen_reg;
        mlast_next   = mlast_reg;
        mstat_next   = mstat_reg;
        movf_next    = movf_reg;

        unique case (state_reg)
            u2g_pkg::ST_IDLE: begin
                if (accept) begin
                    end_next   = s_tlast;
                    state_next = s_tlast ? u2g_pkg::ST_STATUS : u2g_pkg::ST_IDLE;
                    if (!ovf_reg) begin
                        if (phase_reg == u2g_pkg::PH_TWO_LAST ||
                            phase_reg == u2g_pkg::PH_THREE_LAST) begin
                            phase_next = u2g_pkg::PH_IDLE;
                            if (dec_cp < u2g_pkg::ASCII_LIMIT) begin
                                if (bytes_reg >= max_reg) begin
                                    ovf_next = 1'b1;
                                end else begin
                                    single_next = dec_cp[7:0];
                                    state_next  = u2g_pkg::ST_EMIT_1;
                                end
                            end else begin
                                cp_next    = dec_cp;
                                lo_next    = '0;
                                hi_next    = CW'(u2g_pkg::SEARCH_LIMIT);
                                state_next = u2g_pkg::ST_SEARCH;
                            end
                        end else if (phase_reg == u2g_pkg::PH_THREE_SECOND && !s_tlast) begin
                            partial_next = partial_reg | {4'b0, s_tdata[5:0], 6'b0};
                            phase_next   = u2g_pkg::PH_THREE_LAST;
                        end else begin
                            phase_next = u2g_pkg::PH_IDLE;
                            if (!s_tdata[7]) begin
                                if (bytes_reg >= max_reg) begin
                                    ovf_next = 1'b1;
                                end else begin
                                    single_next = s_tdata;
                                    state_next  = u2g_pkg::ST_EMIT_1;
                                end
                            end else if ((s_tdata & u2g_pkg::LEAD2_MASK) == u2g_pkg::LEAD2_CODE
                                         && !s_tlast) begin
                                partial_next = {5'b0, s_tdata[4:0], 6'b0};
                                phase_next   = u2g_pkg::PH_TWO_LAST;
                            end else if ((s_tdata & u2g_pkg::LEAD3_MASK) == u2g_pkg::LEAD3_CODE
                                         && !s_tlast) begin
                                partial_next = {s_tdata[3:0], 12'b0};
                                phase_next   = u2g_pkg::PH_THREE_SECOND;
                            end
                        end
                    end
                end
            end
            u2g_pkg::ST_SEARCH: begin
                if (lo_reg >= hi_reg) begin
                    state_next = end_reg ? u2g_pkg::ST_STATUS : u2g_pkg::ST_IDLE;
                end else if (rom_key == cp_reg) begin
                    state_next = end_reg ? u2g_pkg::ST_STATUS : u2g_pkg::ST_IDLE;
                    if (rom_val != 16'h0000) begin
                        if ({1'b0, bytes_reg} + 17'd2 > {1'b0, max_reg}) begin
                            ovf_next = 1'b1;
                        end else begin
                            pair_next  = rom_val;
                            state_next = u2g_pkg::ST_EMIT_HI;
                        end
                    end
                end else if (rom_key < cp_reg) begin
                    lo_next = mid + CW'(1);
                end else begin
                    hi_next = mid;
                end
            end
            u2g_pkg::ST_EMIT_HI: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    mbyte_next = pair_reg[15:8];
                    mlen_next  = '0;
                    mlast_next = 1'b0;
                    mstat_next = 1'b0;
                    movf_next  = 1'b0;
                    state_next = u2g_pkg::ST_EMIT_LO;
                end
            end
            u2g_pkg::ST_EMIT_LO: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    mbyte_next = pair_reg[7:0];
                    mlen_next  = '0;
                    mlast_next = !end_reg;
                    mstat_next = 1'b0;
                    movf_next  = 1'b0;
                    bytes_next = bytes_reg + 16'd2;
                    state_next = end_reg ? u2g_pkg::ST_STATUS : u2g_pkg::ST_IDLE;
                end
            end
            u2g_pkg::ST_EMIT_1: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    mbyte_next = single_reg;
                    mlen_next  = '0;
                    mlast_next = !end_reg;
                    mstat_next = 1'b0;
                    movf_next  = 1'b0;
                    bytes_next = bytes_reg + 16'd1;
                    state_next = end_reg ? u2g_pkg::ST_STATUS : u2g_pkg::ST_IDLE;
                end
            end
            u2g_pkg::ST_STATUS: begin
                if (out_free) begin
                    mv_next      = 1'b1;
                    mbyte_next   = '0;
                    mlen_next    = ovf_reg ? 16'd0 : bytes_reg;
                    mlast_next   = 1'b1;
                    mstat_next   = 1'b1;
                    movf_next    = ovf_reg;
                    phase_next   = u2g_pkg::PH_IDLE;
                    partial_next = '0;
                    bytes_next   = '0;
                    ovf_next     = 1'b0;
                    state_next   = u2g_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = u2g_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= u2g_pkg::ST_IDLE;
            phase_reg   <= u2g_pkg::PH_IDLE;
            partial_reg <= '0;
            bytes_reg   <= '0;
            ovf_reg     <= 1'b0;
            max_reg     <= u2g_pkg::MAX_OUT_RESET;
            mv_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            partial_reg <= partial_next;
            bytes_reg   <= bytes_next;
            ovf_reg     <= ovf_next;
            mv_reg      <= mv_next;
            if (cfg_wr_en) begin
                max_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cp_reg     <= cp_next;
        end_reg    <= end_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        pair_reg   <= pair_next;
        single_reg <= single_next;
        mbyte_reg  <= mbyte_next;
        mlen_reg   <= mlen_next;
        mlast_reg  <= mlast_next;
        mstat_reg  <= mstat_next;
        movf_reg   <= movf_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {mlen_reg, mbyte_reg};
    assign m_tlast  = mlast_reg;
    assign m_tuser  = {movf_reg, mstat_reg};

endmodule

// File: design/u2g_checker.sv
// Port-level checks for the UTF-8 to GBK converter, bound to the top level.
module u2g_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast,
    input logic [1:0]  m_tuser
);

    // A result item that is not taken holds its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result item changed");

    // The status item always closes the run of its input item.
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast && m_tdata[7:0] == 8'h00)
        else $error("status item malformed");

    // Data items carry no length and no overflow flag.
    a_data_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[23:8] == 16'h0000 && !m_tuser[1])
        else $error("data item carries status fields");

    // An overflowed string reports a zero length.
    a_ovf_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0] && m_tdata[23:8] == 16'h0000)
        else $error("overflow status with nonzero length");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind utf8_to_gbk_stream_converter u2g_checker u_u2g_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// File: sim/testbench.sv
// Self-checking testbench for the UTF-8 to GBK stream converter, with its own predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        WAIT_NONE,
        WAIT_TWO_LAST,
        WAIT_THREE_SECOND,
        WAIT_THREE_LAST
    } utf8_phase_t;

    typedef struct {
        logic [7:0]  out_byte;
        logic        is_status;
        logic        run_last;
        logic [15:0] total_length;
        logic        overflowed;
    } gbk_item_t;

    localparam int MAP_ENTRIES = 49;
    localparam logic [31:0] CP_TO_GBK [MAP_ENTRIES] = '{
        32'h3002_A1A3, 32'h4E00_D2BB, 32'h4E4B_D6AE, 32'h4F60_C4E3, 32'h4F7F_CAB9,
        32'h5206_B7D6, 32'h524D_C7B0, 32'h52A8_B6AF, 32'h5408_BACF, 32'h542F_C6F4,
        32'h5462_C4D8, 32'h571F_CDBF, 32'h5757_BFE9, 32'h5883_BEF9, 32'h5BB6_BCD2,
        32'h5DF2_D2D1, 32'h5E26_B4F8, 32'h5EA6_B6C8, 32'h5F53_B5B1, 32'h5F97_B5C3,
        32'h6210_B3C9, 32'h6211_CED2, 32'h6444_C9E3, 32'h690D_D6B2, 32'h6A21_C4A3,
        32'h6B22_BBB6, 32'h6BCF_C3BF, 32'h6C0F_CAC7, 32'h6C34_CBAE, 32'h6E29_CEC2,
        32'h6E7F_CAAA, 32'h6EF4_B5CE, 32'h7269_CEEF, 32'h73AF_BBB7, 32'h7528_D3C3,
        32'h767E_B0D9, 32'h7684_B5C4, 32'h76C6_C5E8, 32'h7740_D5C5, 32'h78B1_BCE1,
        32'h7BA1_B9DC, 32'h8BB0_BCC7, 32'h8BED_D3EF, 32'h8C22_D0BB, 32'h8FCE_D3AD,
        32'h90FD_B6BC, 32'h9178_CBD8, 32'h97F3_D2F4, 32'hFF0C_A3AC
    };

    class gbk_stream_checker;
        gbk_item_t   pending_gbk[$];
        logic [15:0] budget = 16'hFFFF;
        utf8_phase_t phase = WAIT_NONE;
        logic [15:0] partial_cp = 16'd0;
        logic [15:0] emitted = 16'd0;
        bit          overflow = 1'b0;
        int          errors = 0;

        function void push_item(logic [7:0] b, bit status);
            gbk_item_t it;
            it.out_byte = b;
            it.is_status = status;
            it.run_last = 1'b0;
            it.total_length = (status && !overflow) ? emitted : 16'd0;
            it.overflowed = status && overflow;
            pending_gbk.push_back(it);
        endfunction

        function logic [15:0] gbk_lookup(logic [15:0] cp);
            foreach (CP_TO_GBK[i]) begin
                if (CP_TO_GBK[i][31:16] == cp) return CP_TO_GBK[i][15:0];
            end
            return 16'd0;
        endfunction

        function void put_single(logic [7:0] b);
            if (overflow) return;
            if (emitted >= budget) begin
                overflow = 1'b1;
                return;
            end
            push_item(b, 1'b0);
            emitted = emitted + 16'd1;
        endfunction

        function void put_code_point(logic [15:0] cp);
            logic [15:0] g;
            if (cp < 16'h0080) begin
                put_single(cp[7:0]);
                return;
            end
            g = gbk_lookup(cp);
            if (g == 16'd0 || overflow) return;
            if ({1'b0, emitted} + 17'd2 > {1'b0, budget}) begin
                overflow = 1'b1;
                return;
            end
            push_item(g[15:8], 1'b0);
            push_item(g[7:0], 1'b0);
            emitted = emitted + 16'd2;
        endfunction

        function void start_char(logic [7:0] b, bit last);
            phase = WAIT_NONE;
            if (b < 8'h80) begin
                put_single(b);
            end else if ((b & 8'hE0) == 8'hC0 && !last) begin
                partial_cp = {5'd0, b[4:0], 6'd0};
                phase = WAIT_TWO_LAST;
            end else if ((b & 8'hF0) == 8'hE0 && !last) begin
                partial_cp = {b[3:0], 12'd0};
                phase = WAIT_THREE_SECOND;
            end
        endfunction

        function void accept_utf8_byte(logic [7:0] b, bit last);
            int first;
            first = pending_gbk.size();
            if (!overflow) begin
                case (phase) inside
                    WAIT_TWO_LAST, WAIT_THREE_LAST: begin
                        phase = WAIT_NONE;
                        put_code_point(partial_cp | {10'd0, b[5:0]});
                    end
                    WAIT_THREE_SECOND: begin
                        if (last) begin
                            start_char(b, 1'b1);
                        end else begin
                            partial_cp = partial_cp | {4'd0, b[5:0], 6'd0};
                            phase = WAIT_THREE_LAST;
                        end
                    end
                    default: start_char(b, last);
                endcase
            end
            if (last) begin
                push_item(8'd0, 1'b1);
                phase = WAIT_NONE;
                partial_cp = 16'd0;
                emitted = 16'd0;
                overflow = 1'b0;
            end
            if (pending_gbk.size() > first) pending_gbk[pending_gbk.size() - 1].run_last = 1'b1;
        endfunction

        function void compare(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_output(logic [23:0] tdata, logic tlast, logic [1:0] tuser);
            gbk_item_t want;
            if (pending_gbk.size() == 0) begin
                $display("%0t: unexpected item, expected none, got data 0x%0h last %b user %b",
                         $time, tdata, tlast, tuser);
                errors++;
                return;
            end
            want = pending_gbk.pop_front();
            compare("out_byte", want.out_byte, tdata[7:0]);
            compare("total_length", want.total_length, tdata[23:8]);
            compare("is_status", want.is_status, tuser[0]);
            compare("overflowed", want.overflowed, tuser[1]);
            compare("run_last", want.run_last, tlast);
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = 16'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    gbk_stream_checker sb;
    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    logic [7:0] str_bytes[$];

    utf8_to_gbk_stream_converter i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_served != hold_requests) begin
            holds_served <= holds_served + 1;
            hold_left <= 300;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid === 1'b1 && m_tready) sb.check_output(m_tdata, m_tlast, m_tuser);
            if (s_tvalid && s_tready === 1'b1) sb.accept_utf8_byte(s_tdata, s_tlast);
        end
    end

    task automatic send_item(input logic [7:0] b, input bit last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        do @(posedge aclk); while (s_tready !== 1'b1);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge aclk); while (sb.pending_gbk.size() != 0);
    endtask

    task automatic configure(input logic [15:0] value);
        stop_sending();
        wait_drained();
        repeat (20) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.budget = value;
    endtask

    function automatic logic [7:0] cont_byte(logic [5:0] bits);
        logic [1:0] top;
        top = ($urandom_range(3) == 0) ? 2'($urandom_range(3)) : 2'b10;
        if ({top, bits} == 8'h00) top = 2'b10;
        return {top, bits};
    endfunction

    task automatic push_three(input logic [15:0] cp);
        str_bytes.push_back({4'hE, cp[15:12]});
        str_bytes.push_back(cont_byte(cp[11:6]));
        str_bytes.push_back(cont_byte(cp[5:0]));
    endtask

    task automatic build_string();
        int kind;
        int tail;
        logic [15:0] cp;
        str_bytes.delete();
        repeat ($urandom_range(1, 5)) begin
            kind = $urandom_range(99);
            if (kind < 45) begin
                cp = CP_TO_GBK[$urandom_range(MAP_ENTRIES - 1)][31:16];
                push_three(cp);
            end else if (kind < 62) begin
                str_bytes.push_back(8'($urandom_range(1, 127)));
            end else if (kind < 74) begin
                str_bytes.push_back({3'b110, 5'($urandom_range(31))});
                str_bytes.push_back(cont_byte(6'($urandom_range(63))));
            end else if (kind < 88) begin
                cp = 16'($urandom);
                push_three(cp);
            end else begin
                str_bytes.push_back(8'($urandom_range(128, 255)));
            end
        end
        tail = $urandom_range(9);
        if (tail == 0) begin
            str_bytes.push_back(8'($urandom_range(8'hC0, 8'hEF)));
        end else if (tail == 1) begin
            str_bytes.push_back({4'hE, 4'($urandom_range(15))});
            str_bytes.push_back(8'($urandom_range(1, 255)));
        end
    endtask

    task automatic run_phase(input int n_items, input int pause_at, input int hold_at);
        int sent;
        sent = 0;
        while (sent < n_items) begin
            build_string();
            foreach (str_bytes[i]) begin
                if (sent < n_items) begin
                    if (sent == pause_at) begin
                        stop_sending();
                        wait_drained();
                    end
                    if (sent == hold_at) hold_requests++;
                    send_item(str_bytes[i], i == str_bytes.size() - 1);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        src_idle_pct = 29;
        sink_idle_pct = 80;
        send_item(8'h01, 0); send_item(8'h7F, 0); send_item(8'h41, 1);
        send_item(8'hE3, 0); send_item(8'h80, 0); send_item(8'h82, 0);
        send_item(8'hEF, 0); send_item(8'hBC, 0); send_item(8'h8C, 0);
        send_item(8'h2E, 1);
        send_item(8'hE4, 0); send_item(8'hB8, 0); send_item(8'h81, 0);
        send_item(8'hF8, 0); send_item(8'h80, 0);
        send_item(8'hC1, 0); send_item(8'h81, 0);
        send_item(8'hC3, 0); send_item(8'hA9, 0);
        send_item(8'hE4, 1);
        send_item(8'hE4, 0); send_item(8'h41, 1);
        send_item(8'hC3, 1);
        send_item(8'hFF, 1);

        configure(16'd0);
        run_phase(30, -1, -1);
        configure(16'd1);
        run_phase(25, -1, -1);

        src_idle_pct = 80;
        sink_idle_pct = 29;
        configure(16'd3);
        run_phase(30, -1, -1);
        configure(16'd2);
        run_phase(25, -1, -1);

        src_idle_pct = 0;
        sink_idle_pct = 0;
        configure(16'($urandom_range(4, 40)));
        run_phase(50, 25, -1);
        configure(16'hFFFF);
        run_phase(60, -1, 10);

        stop_sending();
        wait_drained();
        repeat (30) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_gbk.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule

// File: filelist.f
design/u2g_pkg.sv
design/utf8_to_gbk_stream_converter.sv
design/u2g_checker.sv
sim/testbench.sv
